@@ rtl/core/sha256_pkg.sv @@
// Package: payload types, state encoding, constants and round functions for the SHA-256 hasher
package sha256_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       end_of_message;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic        digest_last;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ROUND,
      ST_FOLD,
      ST_PAD,
      ST_EMIT
   } state_type;

   localparam int unsigned CountWidth = 61;
   localparam logic [7:0] PadMark = 8'h80;
   localparam logic [5:0] LastLenStart = 6'd56;

   function automatic logic [31:0] round_k(input logic [5:0] t);
      logic [31:0] k;
      unique case (t)
         6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
         6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
         6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
         6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
         6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
         6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
         6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
         6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
         6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
         6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
         6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
         6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
         default: k = 32'hc67178f2;
      endcase
      return k;
   endfunction

   function automatic logic [31:0] initial_chain(input logic [2:0] i);
      logic [31:0] h;
      unique case (i)
         3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
         3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
         3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
         3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
      endcase
      return h;
   endfunction

   function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

endpackage

@@ rtl/core/sha256_ram.sv @@
// Generic single-port-write, single-read RAM with registered read data
module sha256_ram #(
   parameter int unsigned Width = 32,
   parameter int unsigned Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ rtl/core/sha256_message_hasher_unit.sv @@
// Top level: byte-serial SHA-256 hasher with word-wide block memory and one round per cycle
//
// Accepts one message byte per request while gathering a block; bytes are
// packed into 32-bit words and written to a 16-word block memory. Every 64th
// byte starts a compression: moving the block out of the memory into a
// 16-word schedule window, then one round per cycle (64 rounds, the window
// rolls forward each round), then a fold into the chaining state. No request
// is taken during a compression. An end-of-message request pads the block
// (one word per cycle), compresses once or twice, then presents eight digest
// words, the last flagged, each held until the receiver stops stalling. A
// closing request that also fills the block compresses that block first
// and then pads a fresh one. After the last digest word is taken the state
// returns to the initial hash values for the next message.
module sha256_message_hasher_unit
   import sha256_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);
   state_type state_ff, state_in;

   logic [CountWidth-1:0] count_ff, count_in;
   logic [23:0]           part_ff, part_in;     // bytes of the word being gathered
   logic [6:0]            step_ff, step_in;     // round / word counter
   logic                  final_ff, final_in;   // compression belongs to padding
   logic                  second_ff, second_in; // length block still to go
   logic [31:0]           chain_ff [8];
   logic [31:0]           chain_in [8];
   logic [31:0]           wk_ff [8];
   logic [31:0]           wk_in [8];
   logic [31:0]           sch_ff [16];          // schedule window for rounds
   logic [31:0]           sch_in [16];

   // block memory
   logic        mem_we;
   logic [3:0]  mem_wa, mem_ra;
   logic [31:0] mem_wd, mem_rd;

   sha256_ram #(.Width(32), .Depth(16)) u_block (
      .clock(clock), .wr_en(mem_we), .wr_addr(mem_wa), .wr_data(mem_wd),
      .rd_addr(mem_ra), .rd_data(mem_rd)
   );

   logic        accept;
   logic [5:0]  pos;
   logic [31:0] w_word, g0, g1, s0, s1, ch, mj, t1, t2;
   logic [63:0] bit_len;
   logic [31:0] pad_word;
   logic [3:0]  pad_idx;
   logic [5:0]  base;

   assign accept  = req_valid && !req_stall;
   assign pos     = count_ff[5:0];
   assign bit_len = {count_ff, 3'b000};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_payload.byte_present && pos == 6'd63) begin
                  state_in = ST_LOAD;
               end else if (req_payload.end_of_message) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_LOAD:  if (step_ff == 7'd16) state_in = ST_ROUND;
         ST_ROUND: if (step_ff == 7'd63) state_in = ST_FOLD;
         ST_FOLD: begin
            if (final_ff && !second_ff) state_in = ST_EMIT;
            else if (final_ff || second_ff) state_in = ST_PAD;
            else state_in = ST_IDLE;
         end
         ST_PAD:   if (step_ff == 7'd15) state_in = ST_LOAD;
         ST_EMIT:  if (!rsp_stall && step_ff == 7'd7) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // padding word for index pad_idx of the closing block
   always_comb begin
      pad_idx = step_ff[3:0];
      base    = {pad_idx, 2'b00};
      for (int b = 0; b < 4; b++) begin
         logic [5:0] bp;
         bp = base + 6'(b);
         if (second_ff) begin
            pad_word[31-8*b -: 8] = 8'h00;
         end else if (bp < pos) begin
            pad_word[31-8*b -: 8] = (b == 0) ? part_ff[23:16] :
                                    (b == 1) ? part_ff[15:8] : part_ff[7:0];
         end else if (bp == pos) begin
            pad_word[31-8*b -: 8] = PadMark;
         end else begin
            pad_word[31-8*b -: 8] = 8'h00;
         end
      end
      // length goes in the last two words when it fits
      if ((second_ff || pos < LastLenStart) && pad_idx == 4'd14) pad_word = bit_len[63:32];
      if ((second_ff || pos < LastLenStart) && pad_idx == 4'd15) pad_word = bit_len[31:0];
   end

   // round datapath
   always_comb begin
      g0 = ror(sch_ff[1], 7) ^ ror(sch_ff[1], 18) ^ (sch_ff[1] >> 3);
      g1 = ror(sch_ff[14], 17) ^ ror(sch_ff[14], 19) ^ (sch_ff[14] >> 10);
      w_word = (step_ff < 7'd16) ? sch_ff[0] : (sch_ff[0] + g0 + sch_ff[9] + g1);
      s1 = ror(wk_ff[4], 6) ^ ror(wk_ff[4], 11) ^ ror(wk_ff[4], 25);
      ch = (wk_ff[4] & wk_ff[5]) ^ (~wk_ff[4] & wk_ff[6]);
      t1 = wk_ff[7] + s1 + ch + round_k(step_ff[5:0]) + w_word;
      s0 = ror(wk_ff[0], 2) ^ ror(wk_ff[0], 13) ^ ror(wk_ff[0], 22);
      mj = (wk_ff[0] & wk_ff[1]) ^ (wk_ff[0] & wk_ff[2]) ^ (wk_ff[1] & wk_ff[2]);
      t2 = s0 + mj;
   end

   // datapath and memory control
   always_comb begin
      count_in  = count_ff;
      part_in   = part_ff;
      step_in   = step_ff;
      final_in  = final_ff;
      second_in = second_ff;
      chain_in  = chain_ff;
      wk_in     = wk_ff;
      sch_in    = sch_ff;
      mem_we    = 1'b0;
      mem_wa    = pos[5:2];
      mem_wd    = {part_ff, req_payload.data_byte};
      mem_ra    = step_ff[3:0];
      unique case (state_ff)
         ST_IDLE: begin
            step_in = '0;
            if (accept && req_payload.byte_present) begin
               count_in = count_ff + 1'b1;
               unique case (pos[1:0])
                  2'd0: part_in[23:16] = req_payload.data_byte;
                  2'd1: part_in[15:8]  = req_payload.data_byte;
                  2'd2: part_in[7:0]   = req_payload.data_byte;
                  default: begin
                     mem_we = 1'b1;
                  end
               endcase
               final_in = 1'b0;
            end
            if (accept && req_payload.end_of_message) begin
               if (req_payload.byte_present && pos == 6'd63) begin
                  // full block goes first, padding follows in a fresh block
                  final_in  = 1'b0;
                  second_in = 1'b1;
               end else begin
                  final_in  = 1'b1;
                  second_in = 1'b0;
               end
            end
            for (int i = 0; i < 8; i++) wk_in[i] = chain_ff[i];
         end
         ST_LOAD: begin
            // memory read data is registered, so it arrives the cycle after its address
            step_in = step_ff + 7'd1;
            if (step_ff != 7'd0) sch_in[15] = mem_rd;
            if (step_ff != 7'd0) for (int i = 0; i < 15; i++) sch_in[i] = sch_ff[i+1];
            if (step_ff == 7'd16) begin
               step_in = '0;
               for (int i = 0; i < 8; i++) wk_in[i] = chain_ff[i];
            end
         end
         ST_ROUND: begin
            step_in = step_ff + 7'd1;
            for (int i = 0; i < 15; i++) sch_in[i] = sch_ff[i+1];
            sch_in[15] = w_word;
            wk_in[7] = wk_ff[6]; wk_in[6] = wk_ff[5]; wk_in[5] = wk_ff[4];
            wk_in[4] = wk_ff[3] + t1;
            wk_in[3] = wk_ff[2]; wk_in[2] = wk_ff[1]; wk_in[1] = wk_ff[0];
            wk_in[0] = t1 + t2;
         end
         ST_FOLD: begin
            step_in = '0;
            for (int i = 0; i < 8; i++) chain_in[i] = chain_ff[i] + wk_ff[i];
            if (!final_ff && second_ff) begin
               final_in  = 1'b1;
               second_in = 1'b0;
            end
         end
         ST_PAD: begin
            // words wholly below the byte position already hold message bytes
            mem_we  = second_ff || (pad_idx >= pos[5:2]);
            mem_wa  = pad_idx;
            mem_wd  = pad_word;
            step_in = step_ff + 7'd1;
            if (step_ff == 7'd15) begin
               step_in = '0;
               if (!second_ff && pos >= LastLenStart) second_in = 1'b1;
               else second_in = 1'b0;
            end
         end
         ST_EMIT: begin
            if (!rsp_stall) begin
               step_in = step_ff + 7'd1;
               if (step_ff == 7'd7) begin
                  step_in  = '0;
                  count_in = '0;
                  final_in = 1'b0;
                  for (int i = 0; i < 8; i++) chain_in[i] = initial_chain(3'(i));
               end
            end
         end
         default: ;
      endcase
   end

   // outputs
   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      rsp_valid = (state_ff == ST_EMIT);
      rsp_payload.digest_word = chain_ff[step_ff[2:0]];
      rsp_payload.digest_last = (step_ff[2:0] == 3'd7);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         step_ff   <= '0;
         final_ff  <= 1'b0;
         second_ff <= 1'b0;
         for (int i = 0; i < 8; i++) chain_ff[i] <= initial_chain(3'(i));
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         step_ff   <= step_in;
         final_ff  <= final_in;
         second_ff <= second_in;
         chain_ff  <= chain_in;
      end
      part_ff <= part_in;
      wk_ff   <= wk_in;
      sch_ff  <= sch_in;
   end
endmodule
